// ----- hdl/cwc_pkg.sv -----
// Shared types and constants for the congestion window controller.
`default_nettype none
package cwc_pkg;

    localparam int WIN_W  = 20;
    localparam int REC_W  = WIN_W + 1;
    localparam int ROOT_W = (WIN_W + 1) / 2 + 1;
    localparam int MSS_W  = 16;
    localparam int SEQ_W  = 32;
    localparam int SEG_W  = 16;
    localparam int UNIT_W = MSS_W + WIN_W;
    localparam int PROD_W = SEQ_W + ROOT_W;
    localparam int CFG_W  = WIN_W;

    localparam logic [2:0] MODE_ACK  = 3'd0;
    localparam logic [2:0] MODE_SS   = 3'd1;
    localparam logic [2:0] MODE_CWR  = 3'd2;
    localparam logic [2:0] MODE_LOSS = 3'd3;
    localparam logic [2:0] MODE_INIT = 3'd4;

    localparam logic [1:0] CFG_SEGMENT_SIZE   = 2'd0;
    localparam logic [1:0] CFG_WINDOW_CLAMP   = 2'd1;
    localparam logic [1:0] CFG_INITIAL_WINDOW = 2'd2;

    localparam logic [MSS_W-1:0] MSS_RESET   = 16'd1460;
    localparam logic [WIN_W-1:0] CLAMP_RESET = {WIN_W{1'b1}};
    localparam logic [WIN_W-1:0] INIT_RESET  = 20'd10;

    typedef struct packed {
        logic [2:0]       mode;
        logic [SEQ_W-1:0] ack_seq;
        logic             window_update;
        logic             echo_ce;
        logic             echo_sce;
        logic             window_limited;
        logic [SEG_W-1:0] acked_segments;
    } in_word_t;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [WIN_W-1:0] slow_start_threshold;
        logic [WIN_W-1:0] undo_window;
        logic [REC_W-1:0] sce_recency;
        logic             in_slow_start;
    } out_word_t;

    // effective register values, out-of-range codes already mapped
    typedef struct packed {
        logic [MSS_W-1:0] mss;
        logic [WIN_W-1:0] clamp;
        logic [WIN_W-1:0] init;
    } cfg_t;

endpackage
`default_nettype wire

// ----- hdl/cwc_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module cwc_div #(
    parameter int DW = 48,
    parameter int VW = 36
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient,
    output logic [VW-1:0]      remainder
);
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] div_reg;
    logic [VW:0]   rem_sh;
    logic          qbit;
    logic [VW-1:0] rem_next;

    assign rem_sh   = {rem_reg, quo_reg[DW-1]};
    assign qbit     = rem_sh >= {1'b0, div_reg};
    assign rem_next = qbit ? VW'(rem_sh - {1'b0, div_reg}) : rem_sh[VW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DW-2:0], qbit};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// ----- hdl/cwc_seq.sv -----
// Event sequencer and window state, driving its divider.
`default_nettype none
module cwc_seq #(
    parameter int CREDIT_BITS = 48
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cwc_pkg::cfg_t     cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cwc_pkg::in_word_t in_word,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output cwc_pkg::out_word_t     res_word
);
    import cwc_pkg::*;

    localparam int CB = CREDIT_BITS;
    localparam int SW = ((CB > PROD_W) ? CB : PROD_W) + 2;
    localparam logic signed [SW-1:0] CMAX = {{(SW - CB + 1){1'b0}}, {(CB - 1){1'b1}}};
    localparam logic signed [SW-1:0] CMIN = {{(SW - CB + 1){1'b1}}, {(CB - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SSMUL, S_CREDIT, S_DSTART, S_DIV,
        S_STEP, S_ACKEND, S_ROOT, S_DONE
    } state_t;

    state_t                  state_reg;
    in_word_t                in_reg;
    logic [SEQ_W-1:0]        prior_reg;
    logic [WIN_W-1:0]        cwnd_reg;
    logic [WIN_W-1:0]        ssth_reg;
    logic signed [CB-1:0]    credit_reg;
    logic [WIN_W-1:0]        loss_reg;
    logic [REC_W-1:0]        rec_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [UNIT_W-1:0]       unit_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    cr_en_reg;
    logic                    cr_sub_reg;
    logic                    neg_reg;
    logic [WIN_W-1:0]        steps_reg;
    logic [SEG_W-1:0]        ssrem_reg;

    // ack path
    logic [SEQ_W-1:0]        acked_raw;
    logic [SEQ_W-1:0]        acked_val;
    logic                    ack_skip;
    logic                    sce_hit;
    logic [WIN_W-1:0]        half_c;
    logic [UNIT_W-1:0]       unit_prod;
    logic [PROD_W-1:0]       root_prod;
    // cuts
    logic [WIN_W-1:0]        dec;
    logic [WIN_W-1:0]        dec_c;
    logic [WIN_W-1:0]        cut_new;
    // slow start
    logic [WIN_W:0]          target;
    logic [WIN_W:0]          target_c;
    logic [WIN_W:0]          ss_new;
    logic [SEG_W-1:0]        ss_rem;
    // credit
    logic signed [SW-1:0]    cr_ext;
    logic signed [SW-1:0]    pr_ext;
    logic signed [SW-1:0]    cr_sum;
    logic signed [CB-1:0]    cr_sat;
    // divider and steps
    logic                    div_start;
    logic [CB-1:0]           div_mag;
    logic                    div_done;
    logic [CB-1:0]           div_q;
    logic [UNIT_W-1:0]       div_r;
    logic [WIN_W-1:0]        limit;
    logic [WIN_W-1:0]        steps;
    logic [2*ROOT_W-1:0]     root_sq;
    logic [WIN_W-1:0]        cwnd_step;
    logic                    covers;

    assign acked_raw = in_reg.ack_seq - prior_reg;
    assign acked_val = (acked_raw == '0) ? SEQ_W'(cfg.mss) : acked_raw;
    assign ack_skip  = (acked_raw == '0) && in_reg.window_update;
    assign sce_hit   = in_reg.echo_sce && !in_reg.echo_ce;
    assign half_c    = ((cwnd_reg >> 1) < WIN_W'(2)) ? WIN_W'(2) : (cwnd_reg >> 1);
    assign unit_prod = UNIT_W'(cfg.mss) * UNIT_W'(cwnd_reg);
    assign root_prod = PROD_W'(acked_val) * PROD_W'(root_reg);

    always_comb begin
        case (in_reg.mode)
            MODE_CWR: dec = (rec_reg != '0) ? (cwnd_reg >> 3) : (cwnd_reg >> 2);
            default:  dec = cwnd_reg >> 1;
        endcase
    end
    assign dec_c   = (dec == '0) ? WIN_W'(1) : dec;
    assign cut_new = ({1'b0, cwnd_reg} > ({1'b0, dec_c} + (WIN_W + 1)'(2))) ?
                     (cwnd_reg - dec_c) : WIN_W'(2);

    assign target   = {1'b0, cwnd_reg} + (WIN_W + 1)'(in_reg.acked_segments);
    assign target_c = (target > {1'b0, ssth_reg}) ? {1'b0, ssth_reg} : target;
    assign ss_rem   = in_reg.acked_segments - SEG_W'(target_c - {1'b0, cwnd_reg});
    assign ss_new   = (target_c < {1'b0, cfg.clamp}) ? target_c : {1'b0, cfg.clamp};

    assign cr_ext = SW'(credit_reg);
    assign pr_ext = $signed({{(SW - PROD_W){1'b0}}, prod_reg});
    assign cr_sum = cr_sub_reg ? (cr_ext - pr_ext) : (cr_ext + pr_ext);
    assign cr_sat = (cr_sum > CMAX) ? CB'(CMAX) : (cr_sum < CMIN) ? CB'(CMIN) : CB'(cr_sum);

    assign div_start = (state_reg == S_DSTART) && (credit_reg != '0);
    assign div_mag   = credit_reg[CB-1] ? CB'(-credit_reg) : CB'(credit_reg);

    cwc_div #(.DW(CB), .VW(UNIT_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_mag),
        .divisor   (unit_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb begin
        if (neg_reg) limit = (cwnd_reg > WIN_W'(2)) ? (cwnd_reg - WIN_W'(2)) : '0;
        else         limit = (cfg.clamp > cwnd_reg) ? (cfg.clamp - cwnd_reg) : '0;
    end
    assign steps = (div_q < CB'(limit)) ? div_q[WIN_W-1:0] : limit;

    assign root_sq   = (2 * ROOT_W)'(root_reg) * (2 * ROOT_W)'(root_reg);
    assign cwnd_step = neg_reg ? (cwnd_reg - 1'b1) : (cwnd_reg + 1'b1);
    assign covers    = root_sq >= (2 * ROOT_W)'(cwnd_step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            prior_reg  <= '0;
            cwnd_reg   <= INIT_RESET;
            ssth_reg   <= '1;
            credit_reg <= '0;
            loss_reg   <= '0;
            rec_reg    <= '0;
            root_reg   <= ROOT_W'(1);
            cr_en_reg  <= 1'b0;
            cr_sub_reg <= 1'b0;
            neg_reg    <= 1'b0;
            steps_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        in_reg    <= in_word;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= S_DONE;
                    case (in_reg.mode)
                        MODE_ACK: begin
                            if (!ack_skip) begin
                                prior_reg <= in_reg.ack_seq;
                                unit_reg  <= unit_prod;
                                state_reg <= S_CREDIT;
                                if (sce_hit) begin
                                    prod_reg   <= root_prod;
                                    cr_en_reg  <= 1'b1;
                                    cr_sub_reg <= 1'b1;
                                    loss_reg   <= cwnd_reg;
                                    if (ssth_reg < half_c) ssth_reg <= half_c;
                                    rec_reg    <= REC_W'(cwnd_reg) + 1'b1;
                                end else if ((cwnd_reg >= ssth_reg) &&
                                             in_reg.window_limited) begin
                                    prod_reg   <= PROD_W'(acked_val);
                                    cr_en_reg  <= 1'b1;
                                    cr_sub_reg <= 1'b0;
                                    if (loss_reg < cwnd_reg) loss_reg <= cwnd_reg;
                                end else begin
                                    cr_en_reg <= 1'b0;
                                end
                            end
                        end
                        MODE_SS: begin
                            if (in_reg.window_limited && (cwnd_reg < ssth_reg)) begin
                                cwnd_reg  <= ss_new[WIN_W-1:0];
                                ssrem_reg <= ss_rem;
                                state_reg <= S_SSMUL;
                            end
                        end
                        MODE_CWR, MODE_LOSS: begin
                            loss_reg   <= cwnd_reg;
                            credit_reg <= '0;
                            cwnd_reg   <= cut_new;
                            ssth_reg   <= cwnd_reg >> 1;
                            state_reg  <= S_ROOT;
                        end
                        MODE_INIT: begin
                            prior_reg  <= in_reg.ack_seq;
                            cwnd_reg   <= cfg.init;
                            credit_reg <= '0;
                            loss_reg   <= '0;
                            rec_reg    <= '0;
                            root_reg   <= ROOT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
                S_SSMUL: begin
                    prod_reg   <= PROD_W'(ssrem_reg) * PROD_W'(cfg.mss);
                    cr_en_reg  <= 1'b1;
                    cr_sub_reg <= 1'b0;
                    state_reg  <= S_CREDIT;
                end
                S_CREDIT: begin
                    if (cr_en_reg) credit_reg <= cr_sat;
                    state_reg <= (in_reg.mode == MODE_ACK) ? S_DSTART : S_DONE;
                end
                S_DSTART: begin
                    neg_reg   <= credit_reg[CB-1];
                    state_reg <= (credit_reg != '0) ? S_DIV : S_ACKEND;
                end
                S_DIV: begin
                    if (div_done) begin
                        credit_reg <= neg_reg ? -CB'(div_r) : CB'(div_r);
                        steps_reg  <= steps;
                        state_reg  <= (steps == '0) ? S_ACKEND : S_STEP;
                    end
                end
                S_STEP: begin
                    cwnd_reg <= cwnd_step;
                    if (neg_reg) begin
                        if (covers && (root_reg != '0)) root_reg <= root_reg - 1'b1;
                    end else begin
                        if (!covers) root_reg <= root_reg + 1'b1;
                    end
                    steps_reg <= steps_reg - 1'b1;
                    if (steps_reg == WIN_W'(1)) state_reg <= S_ACKEND;
                end
                S_ACKEND: begin
                    if (rec_reg != '0) rec_reg <= rec_reg - 1'b1;
                    state_reg <= S_DONE;
                end
                S_ROOT: begin
                    if ((root_reg != '0) && (root_sq >= (2 * ROOT_W)'(cwnd_reg)))
                        root_reg <= root_reg - 1'b1;
                    else
                        state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (res_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        res_word.window               = cwnd_reg;
        res_word.slow_start_threshold = ssth_reg;
        res_word.undo_window          = (cwnd_reg > loss_reg) ? cwnd_reg : loss_reg;
        res_word.sce_recency          = rec_reg;
        res_word.in_slow_start        = cwnd_reg < ssth_reg;
    end
endmodule
`default_nettype wire

// ----- hdl/congestion_window_controller_top.sv -----
// Congestion window controller top: config registers, sequencer, output register.
// States: init, unused modes, ignored ack S_EXEC then S_DONE; slow start adds S_SSMUL, S_CREDIT;
//   cwr/loss add S_ROOT per square-root decrement; ack adds S_CREDIT, S_DSTART, S_DIV (divider,
//   one bit a cycle), S_STEP per window segment added or removed, S_ACKEND; no S_DIV at zero credit.
// Throughput: one word at a time; the next is taken once the result moves to the output register.
// Reset: synchronous active-low aresetn; registers to their defaults, window to 10.
`default_nettype none
module congestion_window_controller_top #(
    parameter int CREDIT_BITS = 48
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // configuration write port
    input  wire logic                      cfg_wr_en,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [cwc_pkg::CFG_W-1:0] cfg_wdata,
    // event words in
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire cwc_pkg::in_word_t         s_data,
    // result words out
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output cwc_pkg::out_word_t             m_data
);
    import cwc_pkg::*;

    // raw register values as written
    logic [MSS_W-1:0] mss_reg;
    logic [WIN_W-1:0] clamp_reg;
    logic [WIN_W-1:0] init_reg;
    cfg_t             cfg_eff;

    // output holding register, so the sequencer can finish while m_ready is low
    logic             m_valid_reg;
    out_word_t        m_data_reg;

    logic             res_valid;
    logic             res_ready;
    out_word_t        res_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mss_reg   <= MSS_RESET;
            clamp_reg <= CLAMP_RESET;
            init_reg  <= INIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SEGMENT_SIZE:   mss_reg   <= cfg_wdata[MSS_W-1:0];
                CFG_WINDOW_CLAMP:   clamp_reg <= cfg_wdata;
                CFG_INITIAL_WINDOW: init_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // zero segment size acts as one; windows below two act as two
    always_comb begin
        cfg_eff.mss   = (mss_reg == '0) ? MSS_W'(1) : mss_reg;
        cfg_eff.clamp = (clamp_reg < WIN_W'(2)) ? WIN_W'(2) : clamp_reg;
        cfg_eff.init  = (init_reg < WIN_W'(2)) ? WIN_W'(2) : init_reg;
    end

    cwc_seq #(.CREDIT_BITS(CREDIT_BITS)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_eff),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= res_word;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // window never drops below two segments
    a_win_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.window >= WIN_W'(2)))
        else $error("window below floor");

    // undo window covers the current window
    a_undo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.undo_window >= m_data.window))
        else $error("undo window below window");

    // slow start flag agrees with window and threshold
    a_ss_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.in_slow_start ==
                     (m_data.window < m_data.slow_start_threshold)))
        else $error("slow start flag mismatch");

    // a word in flight blocks the next one
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while busy");
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the congestion window controller: random and directed event words.
`default_nettype none
module testbench;
    import cwc_pkg::*;

    localparam longint CYCLE_LIMIT = 40000000;
    localparam int     HOLD_CYCLES = 600;
    localparam int     DRAIN_CYCLES = 120;
    localparam int     PHASE_WORDS = 205;
    localparam longint CREDIT_TOP = (64'sd1 <<< 47) - 1;
    localparam longint CREDIT_BOTTOM = -CREDIT_TOP - 1;
    // modes 5..7 are spare codes above the last used one
    localparam logic [2:0] MODE_LAST_USED = MODE_INIT;

    // Window engine mirror plus the queue of results it has promised.
    class cwnd_scoreboard;
        logic [MSS_W-1:0] mss_reg;
        logic [WIN_W-1:0] clamp_reg, init_reg;
        logic [31:0]      last_seq;
        longint           cwnd, ssth, loss_win, sce_left, root, credit;
        out_word_t        due[$];
        int               mismatches;

        function new();
            mss_reg = MSS_RESET;
            clamp_reg = CLAMP_RESET;
            init_reg = INIT_RESET;
            last_seq = '0;
            cwnd = eff_init();
            ssth = (1 << WIN_W) - 1;
            loss_win = 0;
            sce_left = 0;
            root = 1;
            credit = 0;
            mismatches = 0;
        endfunction

        function longint eff_mss();
            return (mss_reg == 0) ? 1 : longint'(mss_reg);
        endfunction
        function longint eff_clamp();
            return (clamp_reg < 2) ? 2 : longint'(clamp_reg);
        endfunction
        function longint eff_init();
            return (init_reg < 2) ? 2 : longint'(init_reg);
        endfunction
        function longint clip(longint v);
            if (v > CREDIT_TOP) return CREDIT_TOP;
            if (v < CREDIT_BOTTOM) return CREDIT_BOTTOM;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_SEGMENT_SIZE:   mss_reg = val[MSS_W-1:0];
                CFG_WINDOW_CLAMP:   clamp_reg = val;
                CFG_INITIAL_WINDOW: init_reg = val;
                default: ;
            endcase
        endfunction

        function void cut(int shift);
            longint dec;
            dec = cwnd >> shift;
            if (dec < 1) dec = 1;
            loss_win = cwnd;
            credit = 0;
            cwnd = (cwnd > dec + 2) ? cwnd - dec : 2;
            ssth = loss_win >> 1;
            while (root > 0 && root * root >= cwnd) root--;
        endfunction

        function void ack(in_word_t w);
            longint mss, unit, acked, half, m, k, steps, clampv;
            logic [31:0] delta;
            mss = eff_mss();
            delta = w.ack_seq - last_seq;
            acked = longint'(delta);
            unit = mss * cwnd;
            if (acked == 0 && !w.window_update) acked = mss;
            if (acked == 0) return;   // pure window update: ignored
            last_seq = w.ack_seq;
            if (w.echo_sce && !w.echo_ce) begin
                credit = clip(credit - acked * root);
                loss_win = cwnd;
                half = loss_win >> 1;
                if (half < 2) half = 2;
                if (ssth < half) ssth = half;
                sce_left = cwnd + 1;
            end else if (cwnd >= ssth && w.window_limited) begin
                credit = clip(credit + acked);
                if (loss_win < cwnd) loss_win = cwnd;
            end
            if (unit > 0 && credit <= -unit) begin
                m = -credit;
                k = m / unit;
                credit = -(m % unit);
                steps = (cwnd > 2) ? cwnd - 2 : 0;
                if (k < steps) steps = k;
                for (longint i = 0; i < steps; i++) begin
                    cwnd--;
                    if (root * root >= cwnd && root > 0) root--;
                end
            end
            if (unit > 0 && credit >= unit) begin
                clampv = eff_clamp();
                k = credit / unit;
                credit = credit % unit;
                steps = (cwnd < clampv) ? clampv - cwnd : 0;
                if (k < steps) steps = k;
                for (longint i = 0; i < steps; i++) begin
                    cwnd++;
                    if (root * root < cwnd) root++;
                end
            end
            if (sce_left != 0) sce_left--;
        endfunction

        function void slow_start(in_word_t w);
            longint acked, target, clampv;
            acked = longint'(w.acked_segments);
            clampv = eff_clamp();
            if (!w.window_limited || cwnd >= ssth) return;
            target = cwnd + acked;
            if (target > ssth) target = ssth;
            acked -= target - cwnd;
            cwnd = (target < clampv) ? target : clampv;
            credit = clip(credit + acked * eff_mss());
        endfunction

        // called for every accepted event word
        function void note_event(in_word_t w);
            out_word_t r;
            case (w.mode)
                MODE_ACK:  ack(w);
                MODE_SS:   slow_start(w);
                MODE_CWR:  cut(sce_left != 0 ? 3 : 2);
                MODE_LOSS: cut(1);
                MODE_INIT: begin
                    last_seq = w.ack_seq;
                    cwnd = eff_init();
                    credit = 0;
                    loss_win = 0;
                    sce_left = 0;
                    root = 1;
                end
                default: ;
            endcase
            r.window = cwnd[WIN_W-1:0];
            r.slow_start_threshold = ssth[WIN_W-1:0];
            r.undo_window = (cwnd > loss_win) ? cwnd[WIN_W-1:0] : loss_win[WIN_W-1:0];
            r.sce_recency = sce_left[REC_W-1:0];
            r.in_slow_start = (cwnd < ssth);
            due.push_back(r);
        endfunction

        // called for every accepted result word
        function void check_result(out_word_t got);
            out_word_t exp;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with nothing pending: %p", got);
                return;
            end
            exp = due.pop_front();
            if (got.window !== exp.window
                    || got.slow_start_threshold !== exp.slow_start_threshold
                    || got.undo_window !== exp.undo_window
                    || got.sce_recency !== exp.sce_recency
                    || got.in_slow_start !== exp.in_slow_start) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", exp, got);
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_valid, s_ready;
    in_word_t         s_data;
    logic             m_valid, m_ready;
    out_word_t        m_data;

    cwnd_scoreboard sb = new();
    longint   cycles = 0;
    bit       quiet = 0;        // phase with no gaps on either side
    bit       hold_request = 0; // asks the receiver for one long hold-off
    logic [31:0] gen_seq = '0;  // sequence the stimulus walks along

    congestion_window_controller_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // results are checked at the edge where they are handed off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // receiver: random stalls, plus one long hold so the block backs up
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            n = pick_gap();
            if (hold_request) begin
                hold_request = 0;
                n = HOLD_CYCLES;
            end
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // one word: valid stays up until the block takes it
    task automatic send_word(in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_event(w);
        if (w.mode == MODE_ACK || w.mode == MODE_INIT) gen_seq = w.ack_seq;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // all three registers, written back to back while idle
    task automatic set_regs(logic [CFG_W-1:0] mss, logic [CFG_W-1:0] clampv,
                            logic [CFG_W-1:0] initv);
        logic [CFG_W-1:0] vals [3];
        logic [1:0]       idx [3];
        vals = '{mss, clampv, initv};
        idx = '{CFG_SEGMENT_SIZE, CFG_WINDOW_CLAMP, CFG_INITIAL_WINDOW};
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic in_word_t make_word(logic [2:0] mode, logic [31:0] seq,
                                           bit wu, bit ce, bit sce, bit wl,
                                           logic [15:0] segs);
        in_word_t w;
        w.mode = mode;
        w.ack_seq = seq;
        w.window_update = wu;
        w.echo_ce = ce;
        w.echo_sce = sce;
        w.window_limited = wl;
        w.acked_segments = segs;
        return w;
    endfunction

    // mostly well-formed ack streams with steady forward progress
    function automatic in_word_t random_word();
        in_word_t w;
        int r, s;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        w = make_word(MODE_ACK, gen_seq + $urandom_range(1, 5840),
                      ($urandom_range(0, 9) == 0), ($urandom_range(0, 4) == 0),
                      ($urandom_range(0, 6) == 0), ($urandom_range(0, 4) != 0),
                      SEG_W'($urandom_range(0, 40)));
        if (r >= 55 && r < 72) w.mode = MODE_SS;
        else if (r >= 72 && r < 80) w.mode = MODE_CWR;
        else if (r >= 80 && r < 86) w.mode = MODE_LOSS;
        else if (r >= 86 && r < 91) w.mode = MODE_INIT;
        else if (r >= 96) w.mode = MODE_LAST_USED + 3'($urandom_range(1, 3));
        if (s < 8) w.ack_seq = gen_seq;
        else if (s < 12) w.ack_seq = gen_seq + $urandom_range(0, 200000);
        else if (s == 12) w.ack_seq = $urandom;
        if ($urandom_range(0, 19) == 0) w.acked_segments = SEG_W'($urandom);
        return w;
    endfunction

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_SEGMENT_SIZE;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, each mode, the corner cases
        set_regs(20'd1460, 20'hFFFFF, 20'd10);
        send_word(make_word(MODE_ACK, 32'd0, 0, 0, 0, 1, 16'd0));      // no movement, one mss
        send_word(make_word(MODE_ACK, 32'd0, 1, 0, 0, 1, 16'd0));      // window update: ignored
        send_word(make_word(MODE_SS, 32'd0, 0, 0, 0, 0, 16'hFFFF));    // not limited: no change
        send_word(make_word(MODE_SS, 32'd0, 0, 0, 0, 1, 16'd5));
        send_word(make_word(MODE_ACK, 32'd14600, 0, 0, 1, 1, 16'd0));  // sce-only debit
        send_word(make_word(MODE_ACK, 32'd16060, 0, 1, 1, 1, 16'd0));  // ce masks sce
        send_word(make_word(MODE_CWR, 32'd0, 0, 0, 0, 0, 16'd0));      // recent sce: 1/8
        send_word(make_word(MODE_CWR, 32'd0, 0, 0, 0, 0, 16'd0));
        send_word(make_word(MODE_LOSS, 32'd0, 0, 0, 0, 0, 16'd0));
        send_word(make_word(MODE_LOSS, 32'd0, 0, 0, 0, 0, 16'd0));
        send_word(make_word(MODE_LOSS, 32'd0, 0, 0, 0, 0, 16'd0));      // floor at 2
        send_word(make_word(MODE_ACK, 32'd100000, 0, 0, 0, 1, 16'd0)); // credit grows window
        send_word(make_word(MODE_ACK, 32'hFFFFFFFF, 1, 1, 1, 1, 16'hFFFF));
        send_word(make_word(MODE_LAST_USED + 3'd1, 32'hFFFFFFFF, 1, 1, 1, 1, 16'hFFFF));
        send_word(make_word(MODE_LAST_USED + 3'd2, 32'd0, 0, 0, 0, 0, 16'd0));
        send_word(make_word(MODE_LAST_USED + 3'd3, 32'h5A5A5A5A, 0, 1, 0, 1, 16'h5A5A));
        send_word(make_word(MODE_INIT, 32'hFFFFFFFF, 0, 0, 0, 0, 16'd0));
        send_word(make_word(MODE_ACK, 32'hFFFFFFFF, 0, 0, 0, 1, 16'd0));
        send_word(make_word(MODE_INIT, 32'd0, 1, 1, 1, 1, 16'hFFFF));
        send_word(make_word(MODE_SS, 32'd0, 0, 0, 0, 1, 16'hFFFF));
        drain();

        // random phases over several register settings
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: set_regs(20'd1460, 20'hFFFFF, 20'd10);
                1: set_regs(20'd1, 20'd2, 20'd2);
                2: set_regs(20'd0, 20'd0, 20'd1);          // below range: act as 1, 2, 2
                3: set_regs(20'd536, 20'd64, 20'd4);
                4: set_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
                5: set_regs(20'd9000, 20'd300, 20'd1000);  // init above clamp
                default: set_regs(CFG_W'($urandom_range(1, 65535)),
                                  CFG_W'($urandom_range(2, 2000)),
                                  CFG_W'($urandom_range(2, 64)));
            endcase
            quiet = (p == 3);
            send_word(make_word(MODE_INIT, gen_seq, 0, 0, 0, 1, 16'd0));
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (p == 2 && i == 20) hold_request = 1;
                send_word(random_word());
            end
            drain();
        end

        while (sb.due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.due.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
